// ----- hw/rtl/les_pkg.sv -----
// Shared types and constants for the largest empty square finder.
`default_nettype none

package les_pkg;

   localparam int SIZE_W     = 11;
   localparam int COORD_W    = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   localparam csr_idx_type REG_GRID_WIDTH   = CSR_IDX_W'(0);
   localparam size_type    GRID_WIDTH_RESET = SIZE_W'(1024);

endpackage

`default_nettype wire

// ----- hw/rtl/les_chan_if.sv -----
// Valid/ready channel interfaces for cell items and result items.
`default_nettype none

interface les_req_if;
   import les_pkg::*;

   logic valid;
   logic ready;
   logic is_obstacle;
   logic last_cell;

   modport source (output valid, output is_obstacle, output last_cell, input ready);
   modport sink   (input valid, input is_obstacle, input last_cell, output ready);
endinterface

interface les_rsp_if;
   import les_pkg::*;

   logic      valid;
   logic      ready;
   logic      found;
   coord_type square_col;
   coord_type square_row;
   size_type  square_side;

   modport source (output valid, output found, output square_col, output square_row,
                   output square_side, input ready);
   modport sink   (input valid, input found, input square_col, input square_row,
                   input square_side, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/les_csr.sv -----
// APB-style register port holding the grid width.
`default_nettype none

module les_csr (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  les_pkg::csr_addr_type paddr,
   input  les_pkg::csr_data_type pwdata,
   output les_pkg::csr_data_type prdata,
   output logic                  pready,
   output les_pkg::size_type     grid_width
);
   import les_pkg::*;

   size_type    grid_width_ff;
   size_type    grid_width_in;
   csr_idx_type reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      grid_width_in = grid_width_ff;
      if (wr_en && (reg_idx == REG_GRID_WIDTH)) begin
         grid_width_in = pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
      end else begin
         grid_width_ff <= grid_width_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GRID_WIDTH: prdata = CSR_DATA_W'(grid_width_ff);
         default:        prdata = '0;
      endcase
   end

   assign grid_width = grid_width_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/les_cell.sv -----
// One stage of the line store: holds the square size of one column.
`default_nettype none

module les_cell (
   input  wire               clock,
   input  wire               shift,
   input  wire               inject,
   input  les_pkg::size_type new_size,
   input  les_pkg::size_type prev_size,
   output les_pkg::size_type size
);
   import les_pkg::*;

   size_type size_ff;
   size_type size_in;

   // The cell at the row's entry point takes the fresh size; the others pass
   // their neighbor's value along.
   assign size_in = inject ? new_size : prev_size;

   always_ff @(posedge clock) begin
      if (shift) begin
         size_ff <= size_in;
      end
   end

   assign size = size_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/les_line_store.sv -----
// Chain of cells that delays each square size by exactly one grid row.
`default_nettype none

module les_line_store #(
   parameter int MAX_COLS = 1024,
   parameter int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire               clock,
   input  wire               shift,
   input  wire [COL_W-1:0]   tap,
   input  les_pkg::size_type new_size,
   output les_pkg::size_type up_size
);
   import les_pkg::*;

   size_type chain [MAX_COLS];

   // Sizes enter at cell tap = MAX_COLS - width and leave at the last cell,
   // so the last cell always shows the size one row above the current cell.
   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      size_type prev;
      if (i == 0) begin : g_head
         assign prev = '0;
      end else begin : g_body
         assign prev = chain[i-1];
      end
      les_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .inject    (tap == COL_W'(i)),
         .new_size  (new_size),
         .prev_size (prev),
         .size      (chain[i])
      );
   end

   assign up_size = chain[MAX_COLS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/largest_empty_square_finder.sv -----
// Top level of the largest empty square finder.
//
// Cells of a grid enter on req_chan in row-major order, one item per cell,
// carrying its obstacle bit and a flag on the last cell of the grid. The row
// width is the grid_width register at address 0 of the APB-style port; write
// it only between grids. For each cell the block forms the side of the
// largest free square ending there from the sizes above, to the left and
// upper-left, and keeps the first largest square in raster order.
// Throughput is one cell per clock: the size of a cell needs one three-way
// minimum and one compare, and the row above comes out of a chain of MAX_COLS
// cells that shifts once per accepted cell within the first MAX_ROWS rows.
// One result item leaves on rsp_chan in the cycle after the last cell is
// accepted, from an output register; the next grid may start at once.
// While a result waits and the receiver holds rsp_chan.ready low, req_chan
// takes no further item. Reset sets the width to 1024, empties the result
// register and starts a fresh grid; the line store needs no clearing since
// the first row never reads it.
`default_nettype none

module largest_empty_square_finder #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire                   clock,
   input  wire                   reset,
   les_req_if.sink               req_chan,
   les_rsp_if.source             rsp_chan,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  les_pkg::csr_addr_type paddr,
   input  les_pkg::csr_data_type pwdata,
   output les_pkg::csr_data_type prdata,
   output logic                  pready
);
   import les_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = $clog2(MAX_ROWS + 1);

   size_type         grid_width;
   logic [COL_W:0]   width_eff;
   logic [COL_W:0]   tap_full;
   logic [COL_W:0]   col_next;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   size_type         left_ff, left_in;
   size_type         ul_ff, ul_in;
   size_type         best_ff, best_in;
   coord_type        tl_col_ff, tl_col_in;
   coord_type        tl_row_ff, tl_row_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   coord_type        rsp_col_ff, rsp_row_ff;
   size_type         rsp_side_ff;

   logic             accept, step, finish;
   logic             top_row, leftmost;
   size_type         up_raw, up, ul, lf, min_ul, size_new;
   logic             better;

   les_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .grid_width (grid_width)
   );

   // Width zero acts as one; widths past the store saturate.
   always_comb begin
      if (grid_width == '0) begin
         width_eff = (COL_W+1)'(1);
      end else if (grid_width > MAX_COLS) begin
         width_eff = (COL_W+1)'(MAX_COLS);
      end else begin
         width_eff = (COL_W+1)'(grid_width);
      end
   end

   assign tap_full = (COL_W+1)'(MAX_COLS) - width_eff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign step   = accept && (row_ff < MAX_ROWS);
   assign finish = accept && req_chan.last_cell;

   les_line_store #(
      .MAX_COLS (MAX_COLS),
      .COL_W    (COL_W)
   ) u_line (
      .clock    (clock),
      .shift    (step),
      .tap      (tap_full[COL_W-1:0]),
      .new_size (size_new),
      .up_size  (up_raw)
   );

   assign top_row  = (row_ff == '0);
   assign leftmost = (col_ff == '0);
   assign up       = top_row ? '0 : up_raw;
   assign ul       = (top_row || leftmost) ? '0 : ul_ff;
   assign lf       = leftmost ? '0 : left_ff;
   assign min_ul   = (up < lf) ? up : lf;
   assign size_new = req_chan.is_obstacle ? '0
                   : (SIZE_W'(1) + ((min_ul < ul) ? min_ul : ul));
   assign better   = size_new > best_ff;
   assign col_next = {1'b0, col_ff} + (COL_W+1)'(1);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      ul_in     = ul_ff;
      best_in   = best_ff;
      tl_col_in = tl_col_ff;
      tl_row_in = tl_row_ff;
      if (step) begin
         left_in = size_new;
         ul_in   = up;
         if (better) begin
            best_in   = size_new;
            // Store the top-left corner directly so the result needs no math.
            tl_col_in = COORD_W'(col_ff) + COORD_W'(1) - COORD_W'(size_new);
            tl_row_in = COORD_W'(row_ff) + COORD_W'(1) - COORD_W'(size_new);
         end
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         col_ff    <= '0;
         row_ff    <= '0;
         best_ff   <= '0;
         tl_col_ff <= '0;
         tl_row_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         best_ff   <= best_in;
         tl_col_ff <= tl_col_in;
         tl_row_ff <= tl_row_in;
      end
   end

   // Neighbor sizes are read only once written in the current row.
   always_ff @(posedge clock) begin
      left_ff <= left_in;
      ul_ff   <= ul_in;
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_found_ff <= (best_in != '0);
         rsp_col_ff   <= tl_col_in;
         rsp_row_ff   <= tl_row_in;
         rsp_side_ff  <= best_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.square_col  = rsp_col_ff;
   assign rsp_chan.square_row  = rsp_row_ff;
   assign rsp_chan.square_side = rsp_side_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("last cell accepted without a result item");

   a_last_restarts_grid: assert property (@(posedge clock) disable iff (reset)
      finish |=> (col_ff == '0) && (row_ff == '0) && (best_ff == '0))
      else $error("grid state not cleared after the last cell");

   a_none_found_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (rsp_side_ff == '0) && (rsp_col_ff == '0) && (rsp_row_ff == '0))
      else $error("empty result carries nonzero fields");

   a_found_has_side: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_side_ff != '0))
      else $error("found result with zero side");

   a_stall_only_on_result: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_valid_ff && !rsp_chan.ready))
      else $error("input stalled without a waiting result item");

endmodule

`default_nettype wire
